@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the corner refiner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication under the asynchronous reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("same-cycle implication failed");
// Next-cycle implication under the asynchronous reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle implication failed");
`endif

@@ hw/rtl/pscr_pkg.sv @@
// Types, codes and helpers shared by the corner refiner modules.
`default_nettype none
package pscr_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_PROD,
		ST_SQRT1,
		ST_SQRT2,
		ST_PROD2,
		ST_CMP,
		ST_OMUL,
		ST_OSTART,
		ST_ODIV,
		ST_FIN,
		ST_EMIT_A,
		ST_EMIT_H,
		ST_EMIT_B,
		ST_EMIT_C
	} state_t;

	typedef enum logic {
		DS_SQRT,
		DS_DIV
	} ds_mode_t;

	typedef struct packed {
		logic     start;
		ds_mode_t mode;
	} ds_cmd_t;

	localparam logic [0:0]         REG_COS_THRESHOLD   = 1'b0;
	localparam logic [0:0]         REG_OFFSET_FRACTION = 1'b1;
	localparam logic signed [17:0] COS_RESET           = 18'sd65209;
	localparam logic [15:0]        OFS_RESET           = 16'd6554;

	// Clamp a 35-bit signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
			r = v[31:0];
		end else if (v[34]) begin
			r = {1'b1, {31{1'b0}}};
		end else begin
			r = {1'b0, {31{1'b1}}};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pscr_mul.sv @@
// Shared 32x32 unsigned multiplier with a registered product.
`default_nettype none
module pscr_mul (
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p
);

	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;

endmodule
`default_nettype wire

@@ hw/rtl/pscr_divsqrt.sv @@
// Iterative unit: floor square root of 64 bits or 64 by 32 bit division.
`default_nettype none
module pscr_divsqrt (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pscr_pkg::ds_cmd_t cmd,
	input  wire logic [63:0]       opa,
	input  wire logic [31:0]       opb,
	output logic                   busy,
	output logic                   done,
	output logic [31:0]            res
);

	logic               busy_q;
	logic               done_q;
	logic [5:0]         cnt_q;
	pscr_pkg::ds_mode_t mode_q;
	logic [63:0]        n_q;
	logic [35:0]        rem_q;
	logic [31:0]        root_q;
	logic [31:0]        dvs_q;

	logic [35:0] sh;
	logic [35:0] tr;
	logic        ge;

	always_comb begin
		if (mode_q == pscr_pkg::DS_SQRT) begin
			sh = {rem_q[33:0], n_q[63:62]};
			tr = {2'b00, root_q, 2'b01};
		end else begin
			sh = {rem_q[34:0], n_q[63]};
			tr = {4'b0000, dvs_q};
		end
		ge = (sh >= tr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (cmd.mode == pscr_pkg::DS_SQRT) ? 6'd31 : 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One digit per cycle: two source bits for a root, one for a quotient.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= cmd.mode;
			n_q    <= opa;
			rem_q  <= '0;
			root_q <= '0;
			dvs_q  <= opb;
		end else if (busy_q) begin
			rem_q  <= ge ? (sh - tr) : sh;
			root_q <= {root_q[30:0], ge};
			n_q    <= (mode_q == pscr_pkg::DS_SQRT) ? {n_q[61:0], 2'b00} : {n_q[62:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = root_q;

endmodule
`default_nettype wire

@@ hw/rtl/polyline_sharp_corner_refiner_core.sv @@
// Polyline sharp corner refiner: window control, sequencer and datapath.
// An end point needs no arithmetic. A middle point takes the products, then (unless a
// segment has zero length) two roots of 32 steps and the comparison; a sharp corner adds
// four quotients of 64 steps for its offsets, all on the shared root/divide unit.
// One item at a time: the next input transfer is taken once all results have gone out.
// arst_n clears the window (no point held), the sequencer and both registers to defaults.
`default_nettype none
`include "assert_macros.svh"
module polyline_sharp_corner_refiner_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,   // x, y, arc_pos, owner id
	input  wire logic         s_tlast,   // last_point
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [127:0] m_tdata,   // out_x, out_y, out_arc_pos, out owner id
	output logic              m_tlast,   // run_end
	output logic              m_tuser,   // polyline_end
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_addr,
	input  wire logic [17:0]  cfg_data
);

	pscr_pkg::state_t state_q, state_d;

	logic signed [17:0] cos_q;
	logic [15:0]        of_q;
	logic [1:0]         ps_q;
	logic [2:0]         step_q;
	logic [1:0]         ofs_q;

	logic signed [31:0] prev_x_q, prev_y_q, held_x_q, held_y_q, held_s_q;
	logic [31:0]        held_pid_q;
	logic signed [31:0] cur_x_q, cur_y_q, cur_s_q;
	logic [31:0]        cur_pid_q;
	logic               cur_last_q;
	logic               sharp_q, do_cur_q;

	logic signed [31:0] vx1_q, vy1_q, vx2_q, vy2_q;
	logic [63:0]        q1_q, q2_q, mm_q;
	logic signed [65:0] dot_q;
	logic [31:0]        m1_q, m2_q, d_q;
	logic [81:0]        rr_q;
	logic [47:0]        dp_q;
	logic [31:0]        off_q [4];
	logic signed [31:0] ax_q, ay_q, as_q, bx_q, by_q, bs_q;

	logic [31:0] ux1, uy1, ux2, uy2, mmin, usel, msel;
	logic [17:0] rc;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic signed [65:0] p_ext;

	pscr_pkg::ds_cmd_t ds_cmd;
	logic [63:0] ds_a;
	logic [31:0] ds_b;
	logic        ds_busy, ds_done;
	logic [31:0] ds_res;

	logic commit;
	logic signed [83:0] lhs, rhs;
	logic [48:0] dround;

	assign ux1  = vx1_q[31] ? (~vx1_q + 32'd1) : vx1_q;
	assign uy1  = vy1_q[31] ? (~vy1_q + 32'd1) : vy1_q;
	assign ux2  = vx2_q[31] ? (~vx2_q + 32'd1) : vx2_q;
	assign uy2  = vy2_q[31] ? (~vy2_q + 32'd1) : vy2_q;
	assign mmin = (m1_q < m2_q) ? m1_q : m2_q;
	assign rc   = cos_q[17] ? (~cos_q + 18'd1) : cos_q;
	assign p_ext = {2'b00, mul_p};

	always_comb begin
		case (ofs_q)
			2'd0:    begin usel = ux1; msel = m1_q; end
			2'd1:    begin usel = uy1; msel = m1_q; end
			2'd2:    begin usel = ux2; msel = m2_q; end
			default: begin usel = uy2; msel = m2_q; end
		endcase
	end

	assign lhs    = {{2{dot_q[65]}}, dot_q, 16'b0};
	assign rhs    = cos_q[17] ? -$signed({2'b00, rr_q}) : $signed({2'b00, rr_q});
	assign dround = {1'b0, dp_q} + 49'd32768;

	pscr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	pscr_divsqrt u_divsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ds_cmd),
		.opa    (ds_a),
		.opb    (ds_b),
		.busy   (ds_busy),
		.done   (ds_done),
		.res    (ds_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pscr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, handshakes and shared unit operands.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		m_tdata  = {held_pid_q, held_s_q, held_y_q, held_x_q};
		m_tlast  = 1'b0;
		m_tuser  = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		ds_cmd   = '{start: 1'b0, mode: pscr_pkg::DS_SQRT};
		ds_a     = q1_q;
		ds_b     = '0;
		case (state_q)
			pscr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = pscr_pkg::ST_DIFF;
			end
			pscr_pkg::ST_DIFF: begin
				case (ps_q)
					2'd0:    state_d = cur_last_q ? pscr_pkg::ST_EMIT_C : pscr_pkg::ST_IDLE;
					2'd1:    state_d = pscr_pkg::ST_EMIT_H;
					default: state_d = pscr_pkg::ST_PROD;
				endcase
			end
			pscr_pkg::ST_PROD: begin
				case (step_q)
					3'd0:    begin mul_a = ux1; mul_b = ux1; end
					3'd1:    begin mul_a = uy1; mul_b = uy1; end
					3'd2:    begin mul_a = ux2; mul_b = ux2; end
					3'd3:    begin mul_a = uy2; mul_b = uy2; end
					3'd4:    begin mul_a = ux1; mul_b = ux2; end
					3'd5:    begin mul_a = uy1; mul_b = uy2; end
					default: begin mul_a = '0;  mul_b = '0;  end
				endcase
				if (step_q == 3'd6) begin
					if (q1_q == 64'd0 || q2_q == 64'd0) begin
						state_d = pscr_pkg::ST_EMIT_H;
					end else begin
						ds_cmd  = '{start: 1'b1, mode: pscr_pkg::DS_SQRT};
						ds_a    = q1_q;
						state_d = pscr_pkg::ST_SQRT1;
					end
				end
			end
			pscr_pkg::ST_SQRT1: begin
				if (ds_done) begin
					ds_cmd  = '{start: 1'b1, mode: pscr_pkg::DS_SQRT};
					ds_a    = q2_q;
					state_d = pscr_pkg::ST_SQRT2;
				end
			end
			pscr_pkg::ST_SQRT2: begin
				if (ds_done) state_d = pscr_pkg::ST_PROD2;
			end
			pscr_pkg::ST_PROD2: begin
				case (step_q)
					3'd0:    begin mul_a = m1_q;              mul_b = m2_q;       end
					3'd1:    begin mul_a = {16'b0, of_q};     mul_b = mmin;       end
					3'd2:    begin mul_a = mm_q[31:0];        mul_b = {14'b0, rc}; end
					3'd3:    begin mul_a = mm_q[63:32];       mul_b = {14'b0, rc}; end
					default: begin mul_a = '0;                mul_b = '0;         end
				endcase
				if (step_q == 3'd4) state_d = pscr_pkg::ST_CMP;
			end
			pscr_pkg::ST_CMP: begin
				state_d = (lhs <= rhs) ? pscr_pkg::ST_OMUL : pscr_pkg::ST_EMIT_H;
			end
			pscr_pkg::ST_OMUL: begin
				mul_a   = d_q;
				mul_b   = usel;
				state_d = pscr_pkg::ST_OSTART;
			end
			pscr_pkg::ST_OSTART: begin
				// round half up: add half the divisor before the quotient
				ds_cmd  = '{start: 1'b1, mode: pscr_pkg::DS_DIV};
				ds_a    = mul_p + {33'b0, msel[31:1]};
				ds_b    = msel;
				state_d = pscr_pkg::ST_ODIV;
			end
			pscr_pkg::ST_ODIV: begin
				if (ds_done) state_d = (ofs_q == 2'd3) ? pscr_pkg::ST_FIN : pscr_pkg::ST_OMUL;
			end
			pscr_pkg::ST_FIN: begin
				state_d = pscr_pkg::ST_EMIT_A;
			end
			pscr_pkg::ST_EMIT_A: begin
				m_tvalid = 1'b1;
				m_tdata  = {held_pid_q, as_q, ay_q, ax_q};
				if (m_tready) state_d = pscr_pkg::ST_EMIT_H;
			end
			pscr_pkg::ST_EMIT_H: begin
				m_tvalid = 1'b1;
				m_tlast  = !sharp_q && !do_cur_q;
				if (m_tready) begin
					if (sharp_q)       state_d = pscr_pkg::ST_EMIT_B;
					else if (do_cur_q) state_d = pscr_pkg::ST_EMIT_C;
					else               state_d = pscr_pkg::ST_IDLE;
				end
			end
			pscr_pkg::ST_EMIT_B: begin
				m_tvalid = 1'b1;
				m_tdata  = {held_pid_q, bs_q, by_q, bx_q};
				m_tlast  = !do_cur_q;
				if (m_tready) state_d = do_cur_q ? pscr_pkg::ST_EMIT_C : pscr_pkg::ST_IDLE;
			end
			pscr_pkg::ST_EMIT_C: begin
				m_tvalid = 1'b1;
				m_tdata  = {cur_pid_q, cur_s_q, cur_y_q, cur_x_q};
				m_tlast  = 1'b1;
				m_tuser  = 1'b1;
				if (m_tready) state_d = pscr_pkg::ST_IDLE;
			end
			default: state_d = pscr_pkg::ST_IDLE;
		endcase
	end

	assign commit = (state_d == pscr_pkg::ST_IDLE) && (state_q != pscr_pkg::ST_IDLE);

	// Control registers: configuration, window fill, step counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q  <= pscr_pkg::COS_RESET;
			of_q   <= pscr_pkg::OFS_RESET;
			ps_q   <= 2'd0;
			step_q <= 3'd0;
			ofs_q  <= 2'd0;
		end else begin
			if (cfg_we && cfg_addr == pscr_pkg::REG_COS_THRESHOLD) cos_q <= cfg_data;
			if (cfg_we && cfg_addr == pscr_pkg::REG_OFFSET_FRACTION) of_q <= cfg_data[15:0];
			if (commit) begin
				if (ps_q == 2'd0) ps_q <= cur_last_q ? 2'd0 : 2'd1;
				else              ps_q <= cur_last_q ? 2'd0 : 2'd2;
			end
			if ((state_q == pscr_pkg::ST_PROD || state_q == pscr_pkg::ST_PROD2)
			    && state_d == state_q) begin
				step_q <= step_q + 3'd1;
			end else begin
				step_q <= 3'd0;
			end
			if (state_q == pscr_pkg::ST_CMP) ofs_q <= 2'd0;
			else if (state_q == pscr_pkg::ST_ODIV && ds_done) ofs_q <= ofs_q + 2'd1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cur_x_q    <= s_tdata[31:0];
			cur_y_q    <= s_tdata[63:32];
			cur_s_q    <= s_tdata[95:64];
			cur_pid_q  <= s_tdata[127:96];
			cur_last_q <= s_tlast;
		end
		if (commit && !(ps_q == 2'd0 && cur_last_q)) begin
			prev_x_q   <= held_x_q;
			prev_y_q   <= held_y_q;
			held_x_q   <= cur_x_q;
			held_y_q   <= cur_y_q;
			held_s_q   <= cur_s_q;
			held_pid_q <= cur_pid_q;
		end
		case (state_q)
			pscr_pkg::ST_DIFF: begin
				sharp_q  <= 1'b0;
				do_cur_q <= cur_last_q;
				vx1_q <= pscr_pkg::sat32({{3{held_x_q[31]}}, held_x_q}
					- {{3{prev_x_q[31]}}, prev_x_q});
				vy1_q <= pscr_pkg::sat32({{3{held_y_q[31]}}, held_y_q}
					- {{3{prev_y_q[31]}}, prev_y_q});
				vx2_q <= pscr_pkg::sat32({{3{cur_x_q[31]}}, cur_x_q}
					- {{3{held_x_q[31]}}, held_x_q});
				vy2_q <= pscr_pkg::sat32({{3{cur_y_q[31]}}, cur_y_q}
					- {{3{held_y_q[31]}}, held_y_q});
			end
			pscr_pkg::ST_PROD: begin
				case (step_q)
					3'd1: q1_q <= mul_p;
					3'd2: q1_q <= q1_q + mul_p;
					3'd3: q2_q <= mul_p;
					3'd4: q2_q <= q2_q + mul_p;
					3'd5: dot_q <= (vx1_q[31] ^ vx2_q[31]) ? -p_ext : p_ext;
					3'd6: dot_q <= dot_q + ((vy1_q[31] ^ vy2_q[31]) ? -p_ext : p_ext);
					default: ;
				endcase
			end
			pscr_pkg::ST_SQRT1: if (ds_done) m1_q <= ds_res;
			pscr_pkg::ST_SQRT2: if (ds_done) m2_q <= ds_res;
			pscr_pkg::ST_PROD2: begin
				case (step_q)
					3'd1: mm_q <= mul_p;
					3'd2: dp_q <= mul_p[47:0];
					3'd3: rr_q <= {18'b0, mul_p};
					3'd4: rr_q <= rr_q + {mul_p[49:0], 32'b0};
					default: ;
				endcase
			end
			pscr_pkg::ST_CMP: begin
				sharp_q <= (lhs <= rhs);
				d_q     <= dround[47:16];
			end
			pscr_pkg::ST_ODIV: if (ds_done) off_q[ofs_q] <= ds_res;
			pscr_pkg::ST_FIN: begin
				// pull back along the incoming segment, push on along the outgoing one
				ax_q <= pscr_pkg::sat32(vx1_q[31]
					? {{3{held_x_q[31]}}, held_x_q} + {3'b0, off_q[0]}
					: {{3{held_x_q[31]}}, held_x_q} - {3'b0, off_q[0]});
				ay_q <= pscr_pkg::sat32(vy1_q[31]
					? {{3{held_y_q[31]}}, held_y_q} + {3'b0, off_q[1]}
					: {{3{held_y_q[31]}}, held_y_q} - {3'b0, off_q[1]});
				bx_q <= pscr_pkg::sat32(vx2_q[31]
					? {{3{held_x_q[31]}}, held_x_q} - {3'b0, off_q[2]}
					: {{3{held_x_q[31]}}, held_x_q} + {3'b0, off_q[2]});
				by_q <= pscr_pkg::sat32(vy2_q[31]
					? {{3{held_y_q[31]}}, held_y_q} - {3'b0, off_q[3]}
					: {{3{held_y_q[31]}}, held_y_q} + {3'b0, off_q[3]});
				as_q <= pscr_pkg::sat32({{3{held_s_q[31]}}, held_s_q} - {3'b0, d_q});
				bs_q <= pscr_pkg::sat32({{3{held_s_q[31]}}, held_s_q} + {3'b0, d_q});
			end
			default: ;
		endcase
	end

	`ASSERT_IMPLIES(a_no_overlap, clk, arst_n, m_tvalid, !s_tready)
	`ASSERT_IMPLIES(a_end_is_run_end, clk, arst_n, m_tvalid && m_tuser, m_tlast)
	`ASSERT_IMPLIES(a_unit_idle_on_output, clk, arst_n, ds_busy, !m_tvalid)
	`ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule
`default_nettype wire

@@ tb/polyline_sharp_corner_refiner_core_tb.sv @@
// Self-checking testbench for the polyline sharp corner refiner core.
`timescale 1ns / 1ps
module polyline_sharp_corner_refiner_core_tb;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] arc_pos;
		logic [31:0] owner_id;
		logic        run_end;
		logic        polyline_end;
	} refined_pt_t;

	class corner_scoreboard;
		refined_pt_t expected_q[$];
		refined_pt_t batch[$];
		longint cos_thr;
		longint ofs_frac;
		longint prev_x, prev_y, held_x, held_y, held_s;
		logic [31:0] held_pid;
		int points_seen;
		int mismatches;
		int failures;

		function new();
			cos_thr = longint'(pscr_pkg::COS_RESET);
			ofs_frac = pscr_pkg::OFS_RESET;
			prev_x = 0; prev_y = 0; held_x = 0; held_y = 0; held_s = 0;
			held_pid = 0;
			points_seen = 0;
			mismatches = 0;
			failures = 0;
		endfunction

		function void set_cfg(logic [0:0] idx, logic [17:0] val);
			if (idx == pscr_pkg::REG_COS_THRESHOLD)
				cos_thr = longint'($signed(val));
			else
				ofs_frac = longint'(val[15:0]);
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function logic [63:0] root_floor(logic [63:0] n);
			logic [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function longint along(longint d, longint v, longint mag);
			longint m;
			m = (d * (v < 0 ? -v : v) + mag / 2) / mag;
			return v < 0 ? -m : m;
		endfunction

		function void add_pt(longint x, longint y, longint s, logic [31:0] pid, bit pend);
			refined_pt_t p;
			p.x = clamp32(x);
			p.y = clamp32(y);
			p.arc_pos = clamp32(s);
			p.owner_id = pid;
			p.run_end = 0;
			p.polyline_end = pend;
			batch.insert(batch.size(), p);
		endfunction

		// decide about the held point, given the incoming one
		function void judge_corner(longint cx, longint cy);
			longint vx1, vy1, vx2, vy2, d, mn;
			logic [63:0] q1, q2, m1, m2;
			logic signed [127:0] a1, a2, b1, b2, lhs, rhs, m1w, m2w;
			vx1 = clamp32(held_x - prev_x);
			vy1 = clamp32(held_y - prev_y);
			vx2 = clamp32(cx - held_x);
			vy2 = clamp32(cy - held_y);
			q1 = 64'(vx1 * vx1) + 64'(vy1 * vy1);
			q2 = 64'(vx2 * vx2) + 64'(vy2 * vy2);
			if (q1 == 0 || q2 == 0) begin
				add_pt(held_x, held_y, held_s, held_pid, 0);
				return;
			end
			a1 = vx1; a2 = vx2; b1 = vy1; b2 = vy2;
			lhs = (a1 * a2 + b1 * b2) * 128'sd65536;
			m1 = root_floor(q1);
			m2 = root_floor(q2);
			m1w = m1;
			m2w = m2;
			rhs = 128'(cos_thr) * m1w * m2w;
			if (lhs > rhs) begin
				add_pt(held_x, held_y, held_s, held_pid, 0);
				return;
			end
			mn = longint'(m1 < m2 ? m1 : m2);
			d = (ofs_frac * mn + 32768) >>> 16;
			add_pt(held_x - along(d, vx1, longint'(m1)), held_y - along(d, vy1, longint'(m1)),
				held_s - d, held_pid, 0);
			add_pt(held_x, held_y, held_s, held_pid, 0);
			add_pt(held_x + along(d, vx2, longint'(m2)), held_y + along(d, vy2, longint'(m2)),
				held_s + d, held_pid, 0);
		endfunction

		function void note_input(logic [127:0] data, bit last);
			longint x, y, s;
			logic [31:0] pid;
			x = longint'($signed(data[31:0]));
			y = longint'($signed(data[63:32]));
			s = longint'($signed(data[95:64]));
			pid = data[127:96];
			batch.delete();
			if (points_seen == 0) begin
				if (last) begin
					add_pt(x, y, s, pid, 1);
				end else begin
					held_x = x; held_y = y; held_s = s; held_pid = pid;
					points_seen = 1;
				end
			end else begin
				if (points_seen == 1)
					add_pt(held_x, held_y, held_s, held_pid, 0);
				else
					judge_corner(x, y);
				prev_x = held_x; prev_y = held_y;
				held_x = x; held_y = y; held_s = s; held_pid = pid;
				points_seen = 2;
				if (last) begin
					add_pt(x, y, s, pid, 1);
					points_seen = 0;
				end
			end
			if (batch.size() > 0) batch[batch.size() - 1].run_end = 1;
			foreach (batch[i]) expected_q.insert(expected_q.size(), batch[i]);
		endfunction

		function void check_result(logic [127:0] data, bit rend, bit pend);
			refined_pt_t e, a;
			a.x = data[31:0];
			a.y = data[63:32];
			a.arc_pos = data[95:64];
			a.owner_id = data[127:96];
			a.run_end = rend;
			a.polyline_end = pend;
			if (expected_q.size() == 0) begin
				failures++;
				if (mismatches++ < 10)
					$display("unexpected result x=%0d y=%0d", $signed(a.x), $signed(a.y));
				return;
			end
			e = expected_q.pop_front();
			if (e.x !== a.x || e.y !== a.y || e.arc_pos !== a.arc_pos ||
					e.owner_id !== a.owner_id || e.run_end !== a.run_end ||
					e.polyline_end !== a.polyline_end) begin
				failures++;
				if (mismatches++ < 10)
					$display({"mismatch: exp x=%0d y=%0d s=%0d pid=%h re=%0b pe=%0b,",
						" act x=%0d y=%0d s=%0d pid=%h re=%0b pe=%0b"},
						$signed(e.x), $signed(e.y), $signed(e.arc_pos), e.owner_id,
						e.run_end, e.polyline_end,
						$signed(a.x), $signed(a.y), $signed(a.arc_pos), a.owner_id,
						a.run_end, a.polyline_end);
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         m_tlast;
	logic         m_tuser;
	logic         cfg_we;
	logic [0:0]   cfg_addr;
	logic [17:0]  cfg_data;

	corner_scoreboard refined_sb;
	bit hold_req;
	bit quiet_in;

	polyline_sharp_corner_refiner_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	initial begin
		#10ms;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			refined_sb.note_input(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			refined_sb.check_result(m_tdata, m_tlast, m_tuser);
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// result side: short random stalls, quiet stretches, one long hold-off on request
	initial begin
		int stall_len;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 0;
				repeat (3000) @(posedge clk);
				hold_req = 0;
				m_tready <= 1;
			end else if (!quiet_in && $urandom_range(0, 3) == 0) begin
				stall_len = pick_gap();
				if (stall_len > 0) begin
					m_tready <= 0;
					repeat (stall_len) @(posedge clk);
				end
				m_tready <= 1;
			end else begin
				m_tready <= 1;
			end
		end
	end

	task automatic send_point(longint x, longint y, longint s, logic [31:0] pid, bit last);
		int gap;
		gap = quiet_in ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {pid, s[31:0], y[31:0], x[31:0]};
		s_tlast <= last;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	task automatic drain_and_idle();
		s_tvalid <= 0;
		// let the monitor note the last transfer first
		@(posedge clk);
		while (refined_sb.expected_q.size() > 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [17:0] val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		refined_sb.set_cfg(idx, val);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// random polylines: mostly local random walks, some full range points and repeats
	task automatic random_polylines(int count);
		int sent, len;
		longint x, y, s;
		logic [31:0] pid;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
			pid = $urandom;
			x = longint'($signed(32'($urandom))) >>> $urandom_range(0, 8);
			y = longint'($signed(32'($urandom))) >>> $urandom_range(0, 8);
			s = longint'($signed(32'($urandom))) >>> 4;
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 9))
					0: begin
						x = longint'($signed(32'($urandom)));
						y = longint'($signed(32'($urandom)));
					end
					1: ;
					default: begin
						x = refined_sb.clamp32(x + $signed(32'($urandom_range(0, 200000))) - 100000);
						y = refined_sb.clamp32(y + $signed(32'($urandom_range(0, 200000))) - 100000);
					end
				endcase
				s = refined_sb.clamp32(s + $urandom_range(0, 150000));
				if ($urandom_range(0, 15) == 0) s = longint'($signed(32'($urandom)));
				send_point(x, y, s, ($urandom_range(0, 7) == 0) ? 32'($urandom) : pid,
					i == len - 1);
				sent++;
				if (sent == 20 && count > 30) hold_req = 1;
			end
		end
	endtask

	initial begin
		refined_sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		cfg_we = 0;
		cfg_addr = pscr_pkg::REG_COS_THRESHOLD;
		cfg_data = '0;
		hold_req = 0;
		quiet_in = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// single point, then a two point polyline
		send_point(64'sd2147483647, -64'sd2147483648, 64'sd2147483647, 32'hFFFFFFFF, 1);
		send_point(0, 0, 0, 32'h0, 0);
		send_point(1024, -1024, 1024, 32'h0, 1);
		// square: every middle point is a right angle
		send_point(0, 0, 0, 32'h11, 0);
		send_point(100000, 0, 100000, 32'h12, 0);
		send_point(100000, 100000, 200000, 32'h13, 0);
		send_point(0, 100000, 300000, 32'h14, 1);
		// repeated point gives a zero length segment; then a gentle bend
		send_point(0, 0, 0, 32'h21, 0);
		send_point(5000, 0, 5000, 32'h22, 0);
		send_point(5000, 0, 5000, 32'h23, 0);
		send_point(9000, 3000, 10000, 32'h24, 0);
		send_point(200000, 4000, 200000, 32'h25, 1);
		// far corners of the coordinate range force saturation
		send_point(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 32'h0, 0);
		send_point(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 32'hFFFFFFFF, 0);
		send_point(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 32'hA5A5A5A5, 0);
		send_point(64'sd2147483647, -64'sd2147483648, 0, 32'h5A5A5A5A, 1);
		random_polylines(40);
		drain_and_idle();

		// threshold at one and the largest offset fraction, then a straight diagonal line
		write_reg(pscr_pkg::REG_COS_THRESHOLD, 18'sd65536);
		write_reg(pscr_pkg::REG_OFFSET_FRACTION, 18'd65535);
		send_point(0, 0, 0, 32'h31, 0);
		send_point(4096, 4096, 5000, 32'h32, 0);
		send_point(8192, 8192, 10000, 32'h33, 1);
		quiet_in = 1;
		random_polylines(15);
		quiet_in = 0;
		random_polylines(25);
		drain_and_idle();

		// threshold at minus one: a full reversal is sharp
		write_reg(pscr_pkg::REG_COS_THRESHOLD, -18'sd65536);
		write_reg(pscr_pkg::REG_OFFSET_FRACTION, 18'd0);
		send_point(0, 0, 0, 32'h41, 0);
		send_point(8000, 0, 8000, 32'h42, 0);
		send_point(0, 0, 16000, 32'h43, 1);
		random_polylines(30);
		drain_and_idle();

		write_reg(pscr_pkg::REG_COS_THRESHOLD, 18'($urandom_range(0, 131072)) - 18'd65536);
		write_reg(pscr_pkg::REG_OFFSET_FRACTION, 18'($urandom_range(0, 65535)));
		random_polylines(30);
		drain_and_idle();

		if (refined_sb.failures == 0 && refined_sb.expected_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
